@@ rtl/core/dmp_pkg.sv @@
`default_nettype none

package dmp_pkg;

	// Parse phases; the three pending-error phases skip to the message end
	typedef enum logic [2:0] {
		PH_HDR      = 3'd0,
		PH_AVP_HDR  = 3'd1,
		PH_AVP_DATA = 3'd2,
		PH_CUT_HDR  = 3'd4,
		PH_BAD_LEN  = 3'd5,
		PH_CUT_DATA = 3'd6
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_AVP    = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SHORT_BUF  = 3'd1;
	localparam logic [2:0] ERR_VERSION    = 3'd2;
	localparam logic [2:0] ERR_LEN_OVER   = 3'd3;
	localparam logic [2:0] ERR_AVP_HDR    = 3'd4;
	localparam logic [2:0] ERR_AVP_LEN    = 3'd5;
	localparam logic [2:0] ERR_DATA_CUT   = 3'd6;

	// Protocol constants
	localparam logic [7:0]  DIAM_VERSION   = 8'd1;
	localparam logic [23:0] MSG_HDR_LAST   = 24'd19;
	localparam logic [23:0] MSG_HDR_BYTES  = 24'd20;
	localparam logic [23:0] AVP_HDR_BYTES  = 24'd8;
	localparam logic [23:0] AVP_VHDR_BYTES = 24'd12;

	// Result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [7:0]  command_flags;
		logic [31:0] code_value;
		logic [31:0] application_id;
		logic [31:0] hop_id;
		logic [31:0] end_id;
		logic [7:0]  avp_flag_bits;
		logic [31:0] vendor_value;
		logic [23:0] data_length;
		logic [23:0] data_offset;
		logic        last_of_run;
	} res_t;

	// Events raised by one parsed byte
	typedef struct packed {
		logic       hdr;
		logic       avp;
		logic       term;
		logic [1:0] term_kind;
		logic [2:0] term_err;
	} evt_t;

endpackage

`default_nettype wire

@@ rtl/core/diameter_message_parser.sv @@
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  data_byte, last_in_buffer
// out      source     out_valid/out_stall  kind .. last_of_run (one result per word)
//
// One byte is parsed per cycle while in_stall is low; the parse state updates at the accepting edge.
// A byte yields up to two results, which go into a four-entry result queue.
// in_stall rises while fewer than two queue entries are free, so the input keeps
// one byte per cycle as long as the output drains at least as fast.
// Reset empties the queue and returns the parser to awaiting a message header.
module diameter_message_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_in_buffer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [2:0]       error_code,
	output logic [7:0]       command_flags,
	output logic [31:0]      code_value,
	output logic [31:0]      application_id,
	output logic [31:0]      hop_id,
	output logic [31:0]      end_id,
	output logic [7:0]       avp_flag_bits,
	output logic [31:0]      vendor_value,
	output logic [23:0]      data_length,
	output logic [23:0]      data_offset,
	output logic             last_of_run
);

	// Parse state
	dmp_pkg::phase_t phase_q, phase_n;
	logic [23:0] pos_q, pos_n;
	logic [23:0] len_q, len_n;
	logic [23:0] apos_q, apos_n;
	logic [31:0] asm_q, asm_n;
	logic [7:0]  hflags_q, hflags_n;
	logic [23:0] hcode_q, hcode_n;
	logic [31:0] happ_q, happ_n;
	logic [31:0] hhop_q, hhop_n;
	logic [31:0] acode_q, acode_n;
	logic [7:0]  aflags_q, aflags_n;
	logic [23:0] alen_q, alen_n;
	logic [31:0] avend_q, avend_n;
	logic        drop_q, drop_n;

	// Decode helpers
	logic [31:0] asm_sh;
	logic [24:0] np;
	logic        np_at_end;
	logic [23:0] dl;
	logic [23:0] dl_len;
	logic [31:0] dl_vend;
	logic [24:0] dl_p3;
	logic [24:0] pad;
	logic [23:0] room;
	logic [23:0] pad_eff;
	logic        fin;
	dmp_pkg::evt_t evt;

	// Result queue
	dmp_pkg::res_t res_q [dmp_pkg::QUEUE_DEPTH];
	dmp_pkg::res_t res0, res1, r_hdr, r_avp, r_term;
	logic [dmp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [dmp_pkg::QPTR_W:0]   cnt_q;
	logic [1:0]                 n_push;
	logic                       accept, pop;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (cnt_q > (dmp_pkg::QPTR_W + 1)'(dmp_pkg::QUEUE_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & ~out_stall;

	assign asm_sh    = {asm_q[23:0], data_byte};
	assign np        = {1'b0, pos_q} + 25'd1;
	assign np_at_end = (np >= {1'b0, len_q});

	// Descriptor arithmetic: length, padded skip and room left in the message
	assign dl_p3 = {1'b0, dl} + 25'd3;
	assign pad   = {dl_p3[24:2], 2'b00};
	assign room  = len_q - np[23:0];
	assign pad_eff = (pad > {1'b0, room}) ? room : pad[23:0];

	// Next state and events
	always_comb begin
		logic hdr_done;
		logic vend;
		logic [23:0] hsz;
		hdr_done = 1'b0;
		vend     = aflags_q[7];
		hsz      = dmp_pkg::AVP_HDR_BYTES;
		phase_n  = phase_q;
		pos_n    = pos_q;
		len_n    = len_q;
		apos_n   = apos_q;
		asm_n    = asm_q;
		hflags_n = hflags_q;
		hcode_n  = hcode_q;
		happ_n   = happ_q;
		hhop_n   = hhop_q;
		acode_n  = acode_q;
		aflags_n = aflags_q;
		alen_n   = alen_q;
		avend_n  = avend_q;
		drop_n   = drop_q;
		dl_len   = alen_q;
		dl_vend  = asm_sh;
		dl       = '0;
		fin      = 1'b0;
		evt      = '0;

		if (accept) begin
			if (drop_q) begin
				// drop the rest of the buffer
				if (last_in_buffer) begin
					drop_n  = 1'b0;
					phase_n = dmp_pkg::PH_HDR;
					pos_n   = '0;
					apos_n  = '0;
					asm_n   = '0;
				end
			end else begin
				asm_n = asm_sh;
				pos_n = np[23:0];
				unique case (phase_q)
					dmp_pkg::PH_HDR: begin
						priority if (pos_q == 24'd3) begin
							len_n    = asm_sh[23:0];
							aflags_n = asm_sh[31:24];
						end else if (pos_q == 24'd4) begin
							hflags_n = data_byte;
						end else if (pos_q == 24'd7) begin
							hcode_n = asm_sh[23:0];
						end else if (pos_q == 24'd11) begin
							happ_n = asm_sh;
						end else if (pos_q == 24'd15) begin
							hhop_n = asm_sh;
						end
						if (pos_q < dmp_pkg::MSG_HDR_LAST) begin
							if (last_in_buffer) begin
								evt.term     = 1'b1;
								evt.term_kind = dmp_pkg::KIND_ERROR;
								evt.term_err = dmp_pkg::ERR_SHORT_BUF;
								fin = 1'b1;
							end
						end else begin
							priority if (aflags_q != dmp_pkg::DIAM_VERSION) begin
								evt.term      = 1'b1;
								evt.term_kind = dmp_pkg::KIND_ERROR;
								evt.term_err  = dmp_pkg::ERR_VERSION;
								fin = 1'b1;
							end else if (len_q > dmp_pkg::MSG_HDR_BYTES && last_in_buffer) begin
								evt.term      = 1'b1;
								evt.term_kind = dmp_pkg::KIND_ERROR;
								evt.term_err  = dmp_pkg::ERR_LEN_OVER;
								fin = 1'b1;
							end else begin
								evt.hdr = 1'b1;
								if (len_q <= dmp_pkg::MSG_HDR_BYTES) begin
									evt.term      = 1'b1;
									evt.term_kind = dmp_pkg::KIND_DONE;
									evt.term_err  = dmp_pkg::ERR_NONE;
									fin = 1'b1;
								end else begin
									phase_n = dmp_pkg::PH_AVP_HDR;
									apos_n  = '0;
								end
							end
							aflags_n = '0;
						end
					end
					dmp_pkg::PH_AVP_HDR: begin
						priority if (apos_q == 24'd0 &&
								({1'b0, pos_q} + 25'd8) > {1'b0, len_q}) begin
							phase_n = dmp_pkg::PH_CUT_HDR;
						end else if (apos_q == 24'd3) begin
							acode_n = asm_sh;
						end else if (apos_q == 24'd4) begin
							aflags_n = data_byte;
							if (data_byte[7] && ({1'b0, pos_q} + 25'd8) > {1'b0, len_q})
								phase_n = dmp_pkg::PH_CUT_HDR;
						end else if (apos_q == 24'd7) begin
							alen_n = asm_sh[23:0];
							dl_len = asm_sh[23:0];
							if (vend) begin
								hsz = dmp_pkg::AVP_VHDR_BYTES;
							end else begin
								avend_n = '0;
								dl_vend = '0;
							end
							priority if (asm_sh[23:0] < hsz)
								phase_n = dmp_pkg::PH_BAD_LEN;
							else if (!vend)
								hdr_done = 1'b1;
						end else if (apos_q >= 24'd11) begin
							avend_n  = asm_sh;
							hsz      = dmp_pkg::AVP_VHDR_BYTES;
							hdr_done = 1'b1;
						end
						dl = dl_len - hsz;
						if (phase_n == dmp_pkg::PH_AVP_HDR) begin
							if (hdr_done) begin
								if (({1'b0, np} + {2'b00, dl}) > {2'b00, len_q}) begin
									phase_n = dmp_pkg::PH_CUT_DATA;
								end else begin
									evt.avp = 1'b1;
									if (pad_eff == '0) begin
										apos_n = '0;
										if (np_at_end) begin
											evt.term      = 1'b1;
											evt.term_kind = dmp_pkg::KIND_DONE;
											evt.term_err  = dmp_pkg::ERR_NONE;
											fin = 1'b1;
										end
									end else begin
										phase_n = dmp_pkg::PH_AVP_DATA;
										apos_n  = pad_eff;
									end
								end
							end else begin
								apos_n = apos_q + 24'd1;
							end
						end
					end
					dmp_pkg::PH_AVP_DATA: begin
						logic [23:0] left;
						left = (apos_q != '0) ? apos_q - 24'd1 : apos_q;
						apos_n = left;
						if (left == '0) begin
							phase_n = dmp_pkg::PH_AVP_HDR;
							if (np_at_end) begin
								evt.term      = 1'b1;
								evt.term_kind = dmp_pkg::KIND_DONE;
								evt.term_err  = dmp_pkg::ERR_NONE;
								fin = 1'b1;
							end
						end
					end
					default: begin
						// pending error: advance to the message end
					end
				endcase

				// Raise a pending error once the message end is reached
				if (!fin && np_at_end && (phase_n == dmp_pkg::PH_CUT_HDR ||
						phase_n == dmp_pkg::PH_BAD_LEN || phase_n == dmp_pkg::PH_CUT_DATA)) begin
					evt.term      = 1'b1;
					evt.term_kind = dmp_pkg::KIND_ERROR;
					unique case (phase_n)
						dmp_pkg::PH_CUT_HDR: evt.term_err = dmp_pkg::ERR_AVP_HDR;
						dmp_pkg::PH_BAD_LEN: evt.term_err = dmp_pkg::ERR_AVP_LEN;
						default:             evt.term_err = dmp_pkg::ERR_DATA_CUT;
					endcase
					fin = 1'b1;
				end
				if (!fin && last_in_buffer) begin
					evt.term      = 1'b1;
					evt.term_kind = dmp_pkg::KIND_ERROR;
					evt.term_err  = dmp_pkg::ERR_LEN_OVER;
					fin = 1'b1;
				end

				// Restart on the buffer end, else drop until it
				if (fin) begin
					if (last_in_buffer) begin
						phase_n = dmp_pkg::PH_HDR;
						pos_n   = '0;
						apos_n  = '0;
						asm_n   = '0;
					end else begin
						drop_n = 1'b1;
					end
				end
			end
		end
	end

	// Result words
	always_comb begin
		r_hdr                = '0;
		r_hdr.kind           = dmp_pkg::KIND_HEADER;
		r_hdr.error_code     = dmp_pkg::ERR_NONE;
		r_hdr.command_flags  = hflags_q;
		r_hdr.code_value     = {8'd0, hcode_q};
		r_hdr.application_id = happ_q;
		r_hdr.hop_id         = hhop_q;
		r_hdr.end_id         = asm_sh;
		r_hdr.last_of_run    = ~evt.term;

		r_avp               = '0;
		r_avp.kind          = dmp_pkg::KIND_AVP;
		r_avp.error_code    = dmp_pkg::ERR_NONE;
		r_avp.code_value    = acode_q;
		r_avp.avp_flag_bits = aflags_q;
		r_avp.vendor_value  = dl_vend;
		r_avp.data_length   = dl;
		r_avp.data_offset   = np[23:0];
		r_avp.last_of_run   = ~evt.term;

		r_term             = '0;
		r_term.kind        = evt.term_kind;
		r_term.error_code  = evt.term_err;
		r_term.last_of_run = 1'b1;

		res1 = r_term;
		priority if (evt.hdr)
			res0 = r_hdr;
		else if (evt.avp)
			res0 = r_avp;
		else
			res0 = r_term;
		n_push = {1'b0, evt.hdr | evt.avp} + {1'b0, evt.term};
	end

	assign wr_ptr1 = wr_ptr_q + dmp_pkg::QPTR_W'(1);

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dmp_pkg::PH_HDR;
			pos_q    <= '0;
			len_q    <= '0;
			apos_q   <= '0;
			asm_q    <= '0;
			hflags_q <= '0;
			hcode_q  <= '0;
			happ_q   <= '0;
			hhop_q   <= '0;
			acode_q  <= '0;
			aflags_q <= '0;
			alen_q   <= '0;
			avend_q  <= '0;
			drop_q   <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			len_q    <= len_n;
			apos_q   <= apos_n;
			asm_q    <= asm_n;
			hflags_q <= hflags_n;
			hcode_q  <= hcode_n;
			happ_q   <= happ_n;
			hhop_q   <= hhop_n;
			acode_q  <= acode_n;
			aflags_q <= aflags_n;
			alen_q   <= alen_n;
			avend_q  <= avend_n;
			drop_q   <= drop_n;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dmp_pkg::QPTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + dmp_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + (dmp_pkg::QPTR_W + 1)'(n_push) - (dmp_pkg::QPTR_W + 1)'(pop);
		end
	end

	// Queue storage: hold up to two words per byte
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			res_q[wr_ptr_q] <= res0;
		if (n_push == 2'd2)
			res_q[wr_ptr1] <= res1;
	end

	assign kind           = res_q[rd_ptr_q].kind;
	assign error_code     = res_q[rd_ptr_q].error_code;
	assign command_flags  = res_q[rd_ptr_q].command_flags;
	assign code_value     = res_q[rd_ptr_q].code_value;
	assign application_id = res_q[rd_ptr_q].application_id;
	assign hop_id         = res_q[rd_ptr_q].hop_id;
	assign end_id         = res_q[rd_ptr_q].end_id;
	assign avp_flag_bits  = res_q[rd_ptr_q].avp_flag_bits;
	assign vendor_value   = res_q[rd_ptr_q].vendor_value;
	assign data_length    = res_q[rd_ptr_q].data_length;
	assign data_offset    = res_q[rd_ptr_q].data_offset;
	assign last_of_run    = res_q[rd_ptr_q].last_of_run;

endmodule

`default_nettype wire

@@ bench/diameter_message_parser_tb.sv @@
`default_nettype none

module diameter_message_parser_tb;
	import dmp_pkg::*;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic [7:0]  data_byte      = 8'h00;
	logic        last_in_buffer = 1'b0;
	logic        out_stall      = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [7:0]  command_flags;
	logic [31:0] code_value;
	logic [31:0] application_id;
	logic [31:0] hop_id;
	logic [31:0] end_id;
	logic [7:0]  avp_flag_bits;
	logic [31:0] vendor_value;
	logic [23:0] data_length;
	logic [23:0] data_offset;
	logic        last_of_run;

	diameter_message_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_in_buffer(last_in_buffer),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.error_code(error_code),
		.command_flags(command_flags),
		.code_value(code_value),
		.application_id(application_id),
		.hop_id(hop_id),
		.end_id(end_id),
		.avp_flag_bits(avp_flag_bits),
		.vendor_value(vendor_value),
		.data_length(data_length),
		.data_offset(data_offset),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run hangs
	initial begin
		#10_000_000;
		$display("diameter_message_parser_tb: FAIL");
		$finish;
	end

	// Parser shadow state
	phase_t      ps_phase     = PH_HDR;
	logic [23:0] ps_pos       = '0;
	logic [23:0] ps_msg_len   = '0;
	logic [23:0] ps_avp_idx   = '0;
	logic [31:0] ps_window    = '0;
	logic [7:0]  ps_cmd_flags = '0;
	logic [23:0] ps_cmd_code  = '0;
	logic [31:0] ps_app_id    = '0;
	logic [31:0] ps_hop_id    = '0;
	logic [31:0] ps_avp_code  = '0;
	logic [7:0]  ps_avp_flags = '0;
	logic [23:0] ps_avp_len   = '0;
	logic [31:0] ps_vendor    = '0;
	logic        ps_discard   = 1'b0;

	res_t awaited_results[$];
	logic [7:0] frame[$];
	int tail_pad;

	logic send_idle = 1'b1;
	logic recv_idle = 1'b1;
	int bytes_sent      = 0;
	int buffers_sent    = 0;
	int results_due     = 0;
	int results_checked = 0;
	int fail_count      = 0;
	int kinds_seen[4]   = '{0, 0, 0, 0};

	function automatic res_t blank_result(input logic [1:0] k, input logic [2:0] e);
		res_t r;
		r = '0;
		r.kind = k;
		r.error_code = e;
		return r;
	endfunction

	function automatic void restart_parse();
		ps_phase = PH_HDR;
		ps_pos = '0;
		ps_avp_idx = '0;
		ps_window = '0;
	endfunction

	// Advance the shadow parser by one byte and queue the results it gives
	function automatic void parse_byte(input logic [7:0] b, input logic lst);
		logic [31:0] p, np, len, a, hsz, dl, pad, room;
		logic        fin, hdr_done;
		res_t        r[2];
		int          n;
		p = ps_pos;
		np = p + 1;
		len = ps_msg_len;
		fin = 1'b0;
		hdr_done = 1'b0;
		hsz = AVP_HDR_BYTES;
		n = 0;
		// drop the rest of a finished buffer
		if (ps_discard) begin
			if (lst) begin
				ps_discard = 1'b0;
				restart_parse();
			end
			return;
		end
		ps_window = {ps_window[23:0], b};
		ps_pos = np[23:0];
		case (ps_phase)
			PH_HDR: begin
				// collect header words; version sits in the AVP flags slot for now
				if (p == 3) begin
					ps_msg_len = ps_window[23:0];
					ps_avp_flags = ps_window[31:24];
				end else if (p == 4) begin
					ps_cmd_flags = b;
				end else if (p == 7) begin
					ps_cmd_code = ps_window[23:0];
				end else if (p == 11) begin
					ps_app_id = ps_window;
				end else if (p == 15) begin
					ps_hop_id = ps_window;
				end
				if (p < MSG_HDR_LAST) begin
					if (lst) begin
						r[n] = blank_result(KIND_ERROR, ERR_SHORT_BUF);
						n++;
						fin = 1'b1;
					end
				end else begin
					len = ps_msg_len;
					if (ps_avp_flags != DIAM_VERSION) begin
						r[n] = blank_result(KIND_ERROR, ERR_VERSION);
						n++;
						fin = 1'b1;
					end else if (len > MSG_HDR_BYTES && lst) begin
						r[n] = blank_result(KIND_ERROR, ERR_LEN_OVER);
						n++;
						fin = 1'b1;
					end else begin
						r[n] = blank_result(KIND_HEADER, ERR_NONE);
						r[n].command_flags = ps_cmd_flags;
						r[n].code_value = {8'h00, ps_cmd_code};
						r[n].application_id = ps_app_id;
						r[n].hop_id = ps_hop_id;
						r[n].end_id = ps_window;
						n++;
						if (len <= MSG_HDR_BYTES) begin
							r[n] = blank_result(KIND_DONE, ERR_NONE);
							n++;
							fin = 1'b1;
						end else begin
							ps_phase = PH_AVP_HDR;
							ps_avp_idx = '0;
						end
					end
					ps_avp_flags = '0;
				end
			end
			PH_AVP_HDR: begin
				// walk the AVP header bytes
				a = ps_avp_idx;
				if (a == 0 && p + AVP_HDR_BYTES > len) begin
					ps_phase = PH_CUT_HDR;
				end else if (a == 3) begin
					ps_avp_code = ps_window;
				end else if (a == 4) begin
					ps_avp_flags = b;
					if (b[7] && p + AVP_HDR_BYTES > len)
						ps_phase = PH_CUT_HDR;
				end else if (a == 7) begin
					ps_avp_len = ps_window[23:0];
					if (ps_avp_flags[7])
						hsz = AVP_VHDR_BYTES;
					else
						ps_vendor = '0;
					if (ps_avp_len < hsz)
						ps_phase = PH_BAD_LEN;
					else if (hsz == AVP_HDR_BYTES)
						hdr_done = 1'b1;
				end else if (a >= 11) begin
					ps_vendor = ps_window;
					hsz = AVP_VHDR_BYTES;
					hdr_done = 1'b1;
				end
				if (ps_phase == PH_AVP_HDR) begin
					if (hdr_done) begin
						dl = ps_avp_len - hsz;
						if (np + dl > len) begin
							ps_phase = PH_CUT_DATA;
						end else begin
							// descriptor, then skip padded data clipped at the message end
							pad = (dl + 3) & ~32'd3;
							room = len - np;
							r[n] = blank_result(KIND_AVP, ERR_NONE);
							r[n].code_value = ps_avp_code;
							r[n].avp_flag_bits = ps_avp_flags;
							r[n].vendor_value = ps_vendor;
							r[n].data_length = dl[23:0];
							r[n].data_offset = np[23:0];
							n++;
							if (pad > room)
								pad = room;
							if (pad == 0) begin
								ps_avp_idx = '0;
								if (np >= len) begin
									r[n] = blank_result(KIND_DONE, ERR_NONE);
									n++;
									fin = 1'b1;
								end
							end else begin
								ps_phase = PH_AVP_DATA;
								ps_avp_idx = pad[23:0];
							end
						end
					end else begin
						ps_avp_idx = a + 1;
					end
				end
			end
			PH_AVP_DATA: begin
				if (ps_avp_idx > 0)
					ps_avp_idx--;
				if (ps_avp_idx == 0) begin
					ps_phase = PH_AVP_HDR;
					if (np >= len) begin
						r[n] = blank_result(KIND_DONE, ERR_NONE);
						n++;
						fin = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// pending errors wait for the message end
		if (!fin && (ps_phase == PH_CUT_HDR || ps_phase == PH_BAD_LEN ||
				ps_phase == PH_CUT_DATA) && np >= len) begin
			r[n] = blank_result(KIND_ERROR, ps_phase);
			n++;
			fin = 1'b1;
		end
		if (!fin && lst) begin
			r[n] = blank_result(KIND_ERROR, ERR_LEN_OVER);
			n++;
			fin = 1'b1;
		end
		if (fin) begin
			if (lst)
				restart_parse();
			else
				ps_discard = 1'b1;
		end
		if (n > 0)
			r[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			awaited_results.push_back(r[i]);
		results_due += n;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result(input res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: result with none expected, kind %0d, got %0h", $time, got.kind, got);
			fail_count++;
			return;
		end
		want = awaited_results.pop_front();
		results_checked++;
		kinds_seen[want.kind]++;
		check_field("kind", want.kind, got.kind);
		check_field("error_code", want.error_code, got.error_code);
		check_field("command_flags", want.command_flags, got.command_flags);
		check_field("code_value", want.code_value, got.code_value);
		check_field("application_id", want.application_id, got.application_id);
		check_field("hop_id", want.hop_id, got.hop_id);
		check_field("end_id", want.end_id, got.end_id);
		check_field("avp_flag_bits", want.avp_flag_bits, got.avp_flag_bits);
		check_field("vendor_value", want.vendor_value, got.vendor_value);
		check_field("data_length", want.data_length, got.data_length);
		check_field("data_offset", want.data_offset, got.data_offset);
		check_field("last_of_run", want.last_of_run, got.last_of_run);
	endtask

	// Take results with random stalls and check each one
	initial begin : result_sink
		int   gap;
		res_t got;
		forever begin
			gap = (recv_idle && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			got = {kind, error_code, command_flags, code_value, application_id, hop_id,
				end_id, avp_flag_bits, vendor_value, data_length, data_offset, last_of_run};
			check_result(got);
		end
	end

	// Offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = (send_idle && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_in_buffer <= lst;
		do @(posedge clk); while (in_stall !== 1'b0);
		parse_byte(b, lst);
		bytes_sent++;
	endtask

	// Hold the input until every queued result has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic void push_bytes(input logic [31:0] v, input int cnt);
		for (int i = cnt - 1; i >= 0; i--)
			frame.push_back(v[8*i +: 8]);
	endfunction

	function automatic void begin_frame(input logic [7:0] ver, input logic [7:0] flags,
			input logic [23:0] code, input logic [31:0] app, input logic [31:0] hop,
			input logic [31:0] eid);
		frame = {};
		tail_pad = 0;
		push_bytes(ver, 1);
		push_bytes(32'h0, 3);
		push_bytes(flags, 1);
		push_bytes(code, 3);
		push_bytes(app, 4);
		push_bytes(hop, 4);
		push_bytes(eid, 4);
	endfunction

	// Append an AVP; adj skews the length field away from the true size
	function automatic void add_avp(input logic [31:0] code, input logic [7:0] flags,
			input logic [31:0] vendor, input int dlen, input int adj);
		int hsz, padded;
		hsz = flags[7] ? AVP_VHDR_BYTES : AVP_HDR_BYTES;
		padded = (dlen + 3) / 4 * 4;
		push_bytes(code, 4);
		push_bytes(flags, 1);
		push_bytes(hsz + dlen + adj, 3);
		if (flags[7])
			push_bytes(vendor, 4);
		repeat (padded) frame.push_back($urandom_range(0, 255));
		tail_pad = padded - dlen;
	endfunction

	// Send the frame as one buffer: patch the length, drop a tail, add trailing bytes
	task automatic send_frame(input logic [23:0] msg_len, input int cut, input int extra);
		int count;
		if (frame.size() >= 4) begin
			frame[1] = msg_len[23:16];
			frame[2] = msg_len[15:8];
			frame[3] = msg_len[7:0];
		end
		count = frame.size() - cut;
		for (int i = 0; i < count; i++)
			send_byte(frame[i], (i == count - 1) && (extra == 0));
		for (int i = 0; i < extra; i++)
			send_byte($urandom_range(0, 255), i == extra - 1);
		buffers_sent++;
	endtask

	task automatic test_header_checks();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		// short buffers: one byte, then one short of a header
		begin_frame(DIAM_VERSION, 8'h80, 24'h000101, '0, '0, '0);
		send_frame(MSG_HDR_BYTES, 19, 0);
		send_frame(MSG_HDR_BYTES, 1, 0);
		// bad version, the second with trailing bytes
		begin_frame(8'h00, 8'h00, 24'h0, '0, '0, '0);
		send_frame(MSG_HDR_BYTES, 0, 0);
		begin_frame(8'hFF, 8'hFF, 24'hFFFFFF, '1, '1, '1);
		send_frame(MSG_HDR_BYTES, 0, 3);
		// header-only messages
		begin_frame(DIAM_VERSION, 8'h00, 24'h0, '0, '0, '0);
		send_frame(MSG_HDR_BYTES, 0, 0);
		begin_frame(DIAM_VERSION, 8'hFF, 24'hFFFFFF, '1, '1, '1);
		send_frame(24'h0, 0, 0);
		// length beyond the buffer
		send_frame(24'hFFFFFF, 0, 0);
		send_frame(24'd21, 0, 0);
		wait_for_results();
	endtask

	task automatic test_avp_walk();
		send_idle = 1'b0;
		recv_idle = 1'b1;
		// descriptor and done from one byte
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp(32'h0, 8'h00, '0, 0, 0);
		send_frame(frame.size(), 0, 0);
		// several AVPs, with and without vendor, every padding amount
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp(32'hFFFFFFFF, 8'h7F, '0, 1, 0);
		add_avp($urandom, 8'hFF, 32'hFFFFFFFF, 4, 0);
		add_avp($urandom, 8'h80, 32'h0, 5, 0);
		add_avp($urandom, 8'h40, $urandom, 3, 0);
		add_avp($urandom, 8'h00, $urandom, 2, 0);
		send_frame(frame.size(), 0, 0);
		// final padding left outside the message
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 1, 0);
		send_frame(frame.size() - 3, 3, 0);
		// buffer ends right at a descriptor
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 0, 0);
		add_avp($urandom, 8'h00, '0, 4, 0);
		send_frame(frame.size(), 12, 0);
		// vendor AVP, then bytes past the message end
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h80, $urandom, 0, 0);
		send_frame(frame.size(), 0, 5);
		wait_for_results();
	endtask

	task automatic test_avp_errors();
		send_idle = 1'b1;
		recv_idle = 1'b0;
		// AVP header cut by the message length, plain and with vendor
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 4, 0);
		send_frame(24, 0, 0);
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h80, $urandom, 0, 0);
		send_frame(28, 0, 0);
		// AVP length below its header size
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 0, -8);
		send_frame(frame.size(), 0, 0);
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'hC0, $urandom, 0, -1);
		send_frame(frame.size(), 0, 2);
		// data running past the message, a little and as far as it goes
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 4, 4);
		send_frame(frame.size(), 0, 0);
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 0, 24'hFFFFF7);
		send_frame(frame.size(), 0, 0);
		// short buffer overrides a pending AVP error
		begin_frame(DIAM_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom);
		add_avp($urandom, 8'h00, '0, 0, -8);
		add_avp($urandom, 8'h00, '0, 8, 0);
		send_frame(frame.size(), 4, 0);
		wait_for_results();
	endtask

	// Mostly well-formed messages with random content, some damaged, some noise
	task automatic test_random_frames();
		int start_bytes, start_results, avp_count, dlen, adj, len_field, sent, extra;
		start_bytes = bytes_sent;
		start_results = results_due;
		while (bytes_sent - start_bytes < 450 || results_due - start_results < 50) begin
			if ($urandom_range(0, 7) == 0)
				send_idle = !send_idle;
			if ($urandom_range(0, 7) == 0)
				recv_idle = !recv_idle;
			if ($urandom_range(0, 11) == 0)
				wait_for_results();
			if ($urandom_range(0, 9) == 0) begin
				frame = {};
				repeat ($urandom_range(1, 40)) frame.push_back($urandom_range(0, 255));
				send_frame($urandom_range(0, 64), 0, 0);
			end else begin
				begin_frame(($urandom_range(0, 19) == 0) ? 8'($urandom) : DIAM_VERSION,
					$urandom, $urandom, $urandom, $urandom, $urandom);
				avp_count = $urandom_range(0, 4);
				repeat (avp_count) begin
					dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
						: $urandom_range(0, 12);
					adj = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 20)) - 10 : 0;
					add_avp($urandom, $urandom, $urandom, dlen, adj);
				end
				len_field = frame.size();
				sent = frame.size();
				if (avp_count > 0 && $urandom_range(0, 2) == 0) begin
					len_field -= tail_pad;
					sent -= tail_pad;
				end
				if ($urandom_range(0, 9) == 0)
					len_field += int'($urandom_range(0, 16)) - 8;
				if (len_field < 0)
					len_field = 0;
				if ($urandom_range(0, 9) == 0)
					sent = $urandom_range(1, sent);
				extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
				send_frame(len_field, frame.size() - sent, extra);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_checks();
		test_avp_walk();
		test_avp_errors();
		test_random_frames();
		wait_for_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d buffers; checked %0d results.",
			bytes_sent, buffers_sent, results_checked);
		$display("Results by kind: %0d headers, %0d AVPs, %0d done, %0d errors.",
			kinds_seen[KIND_HEADER], kinds_seen[KIND_AVP], kinds_seen[KIND_DONE],
			kinds_seen[KIND_ERROR]);
		if (fail_count == 0)
			$display("diameter_message_parser_tb: PASS");
		else
			$display("diameter_message_parser_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
